FILE: design/smig_pkg.sv
// Shared types and constants for the split member index gather block.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package smig_pkg;

    localparam int ID_W     = 11;
    localparam int SPLIT_W  = 6;
    localparam int CNT_W    = 6;
    localparam int SLOT_W   = 5;

    localparam int QUEUE_DEPTH = 4;

    // Padding value of an empty result slot (-1 in 11 bits)
    localparam logic [ID_W-1:0] PAD_INDEX = 11'h7FF;

    // Input action codes
    localparam logic [1:0] ACT_LOAD_ASSOC = 2'd0;
    localparam logic [1:0] ACT_LOAD_BOUND = 2'd1;
    localparam logic [1:0] ACT_QUERY      = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_MATCH_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_OTHER_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_EMIT_OTHERS  = 2'd3;

    typedef enum logic [1:0] {
        CMD_ASSOC = 2'd0,
        CMD_BOUND = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ID_W-1:0]    addr;
        logic [ID_W-1:0]    value;
        logic [ID_W-1:0]    id;
        logic [SPLIT_W-1:0] split;
        logic               split_ok;
    } cmd_t;

    // Configuration after saturation to the build limits
    typedef struct packed {
        logic [ID_W-1:0]  vc;
        logic [CNT_W-1:0] ml;
        logic [CNT_W-1:0] ol;
        logic             emit;
    } cfg_t;

endpackage

`default_nettype wire

FILE: design/smig_front.sv
// Front end: accepts input transactions and classifies them into commands.
// Drops unknown actions and out-of-range loads. Depends on smig_pkg.
`default_nettype none

module smig_front #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_SPLITS   = 64
) (
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [39:0]         s_tdata,
    input  wire logic [1:0]          s_tuser,
    input  wire logic                q_full,
    output logic                     q_push,
    output smig_pkg::cmd_t           q_cmd
);

    logic [10:0] load_address;
    logic [11:0] load_value;
    logic [10:0] object_id;
    logic [5:0]  split_index;
    logic        keep;

    assign load_address = s_tdata[10:0];
    assign load_value   = s_tdata[22:11];
    assign object_id    = s_tdata[33:23];
    assign split_index  = s_tdata[39:34];

    always_comb
    begin
        q_cmd          = '0;
        q_cmd.addr     = load_address;
        q_cmd.value    = load_value[10:0];
        q_cmd.id       = object_id;
        q_cmd.split    = split_index;
        q_cmd.split_ok = (32'(split_index) < MAX_SPLITS);
        keep           = 1'b0;
        case (s_tuser)
            smig_pkg::ACT_LOAD_ASSOC:
            begin
                q_cmd.kind = smig_pkg::CMD_ASSOC;
                keep       = (32'(load_address) < MAX_VERTICES);
            end
            smig_pkg::ACT_LOAD_BOUND:
            begin
                q_cmd.kind = smig_pkg::CMD_BOUND;
                keep       = (32'(load_address) <= MAX_SPLITS);
            end
            smig_pkg::ACT_QUERY:
            begin
                q_cmd.kind = smig_pkg::CMD_QUERY;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;

endmodule

`default_nettype wire

FILE: design/smig_queue.sv
// Short command queue between front end and back end.
// Holds classified commands in order. Depends on smig_pkg.
`default_nettype none

module smig_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire smig_pkg::cmd_t  push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output smig_pkg::cmd_t       pop_cmd,
    output logic                 empty
);

    localparam int PTR_W = $clog2(smig_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(smig_pkg::QUEUE_DEPTH + 1);

    smig_pkg::cmd_t   entry_reg [smig_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(smig_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(smig_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(smig_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: design/smig_back.sv
// Back end: executes loads into the association and boundary memories and
// scans splits for queries, driving the result register. Depends on smig_pkg.
`default_nettype none

module smig_back #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_SPLITS   = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire smig_pkg::cfg_t  cfg,
    input  wire logic            q_empty,
    input  wire smig_pkg::cmd_t  q_cmd,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [15:0]          m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int VA_W = $clog2(MAX_VERTICES);
    localparam int BA_W = $clog2(MAX_SPLITS + 1);
    localparam int ID_W = smig_pkg::ID_W;
    localparam int CNT_W = smig_pkg::CNT_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_BLO  = 5'b00010,
        ST_BHI  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_PAD  = 5'b10000
    } state_t;

    logic [ID_W-1:0] assoc_mem [MAX_VERTICES];
    logic [ID_W-1:0] bound_mem [MAX_SPLITS + 1];
    logic [ID_W-1:0] assoc_q;
    logic [ID_W-1:0] bound_q;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [ID_W-1:0]            out_index_reg, out_index_next;
    logic [smig_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic   out_sel_reg, out_sel_next;
    logic   out_last_reg, out_last_next;

    logic [ID_W-1:0]             id_reg, id_next;
    logic [smig_pkg::SPLIT_W-1:0] split_reg, split_next;
    logic                        split_ok_reg, split_ok_next;
    logic [ID_W-1:0]             start_reg, start_next;
    logic [ID_W-1:0]             end_reg, end_next;
    logic [ID_W-1:0]             v_reg, v_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic                        sel_reg, sel_next;

    logic             assoc_we, bound_we;
    logic             assoc_rd_en, bound_rd_en;
    logic [VA_W-1:0]  assoc_rd_addr;
    logic [BA_W-1:0]  bound_rd_addr;

    logic             out_free;
    logic [CNT_W-1:0] lim;
    logic             more_slots;
    logic             final_list;
    logic             last_slot;
    logic             hit;

    assign out_free   = !out_valid_reg || m_tready;
    assign lim        = sel_reg ? cfg.ol : cfg.ml;
    assign more_slots = (n_reg < lim);
    // The non-matching list closes the query unless it is off or empty
    assign final_list = sel_reg || !(cfg.emit && (cfg.ol != '0));
    assign last_slot  = final_list && ((n_reg + 1'b1) == lim);
    assign hit        = ((assoc_q == id_reg) == !sel_reg);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_index_next = out_index_reg;
        out_slot_next  = out_slot_reg;
        out_sel_next   = out_sel_reg;
        out_last_next  = out_last_reg;
        id_next        = id_reg;
        split_next     = split_reg;
        split_ok_next  = split_ok_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        v_next         = v_reg;
        n_next         = n_reg;
        sel_next       = sel_reg;
        q_pop          = 1'b0;
        assoc_we       = 1'b0;
        bound_we       = 1'b0;
        assoc_rd_en    = 1'b0;
        bound_rd_en    = 1'b0;
        assoc_rd_addr  = VA_W'(v_reg + 1'b1);
        bound_rd_addr  = BA_W'(split_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        smig_pkg::CMD_ASSOC: assoc_we = 1'b1;
                        smig_pkg::CMD_BOUND: bound_we = 1'b1;
                        smig_pkg::CMD_QUERY:
                        begin
                            id_next       = q_cmd.id;
                            split_next    = q_cmd.split;
                            split_ok_next = q_cmd.split_ok;
                            bound_rd_en   = 1'b1;
                            bound_rd_addr = BA_W'(q_cmd.split);
                            state_next    = ST_BLO;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BLO:
            begin
                start_next    = split_ok_reg ? bound_q : '0;
                bound_rd_en   = 1'b1;
                bound_rd_addr = BA_W'({1'b0, split_reg} + 7'd1);
                state_next    = ST_BHI;
            end
            ST_BHI:
            begin
                if (!split_ok_reg)
                begin
                    end_next = '0;
                end
                else
                begin
                    end_next = (bound_q > cfg.vc) ? cfg.vc : bound_q;
                end
                v_next        = start_reg;
                n_next        = '0;
                sel_next      = 1'b0;
                assoc_rd_en   = 1'b1;
                assoc_rd_addr = VA_W'(start_reg);
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if ((v_reg < end_reg) && more_slots)
                begin
                    // Hold the vertex while a hit waits for the result register
                    if (!hit || out_free)
                    begin
                        if (hit)
                        begin
                            out_valid_next = 1'b1;
                            out_index_next = v_reg;
                            out_slot_next  = n_reg[smig_pkg::SLOT_W-1:0];
                            out_sel_next   = sel_reg;
                            out_last_next  = last_slot;
                            n_next         = n_reg + 1'b1;
                        end
                        v_next      = v_reg + 1'b1;
                        assoc_rd_en = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (more_slots)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = smig_pkg::PAD_INDEX;
                        out_slot_next  = n_reg[smig_pkg::SLOT_W-1:0];
                        out_sel_next   = sel_reg;
                        out_last_next  = last_slot;
                        n_next         = n_reg + 1'b1;
                    end
                end
                else if (!sel_reg && cfg.emit)
                begin
                    // Rescan the split for the non-matching list
                    sel_next      = 1'b1;
                    n_next        = '0;
                    v_next        = start_reg;
                    assoc_rd_en   = 1'b1;
                    assoc_rd_addr = VA_W'(start_reg);
                    state_next    = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_slot_reg  <= out_slot_next;
        out_sel_reg   <= out_sel_next;
        out_last_reg  <= out_last_next;
        id_reg        <= id_next;
        split_reg     <= split_next;
        split_ok_reg  <= split_ok_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        v_reg         <= v_next;
        n_reg         <= n_next;
        sel_reg       <= sel_next;
    end

    always_ff @(posedge clk)
    begin
        if (assoc_we)
        begin
            assoc_mem[VA_W'(q_cmd.addr)] <= q_cmd.value;
        end
        if (assoc_rd_en)
        begin
            assoc_q <= assoc_mem[assoc_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bound_we)
        begin
            bound_mem[BA_W'(q_cmd.addr)] <= q_cmd.value;
        end
        if (bound_rd_en)
        begin
            bound_q <= bound_mem[bound_rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_slot_reg, out_index_reg};
    assign m_tuser  = out_sel_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: design/split_member_index_gather_top.sv
// Top level of the split member index gather block: configuration registers,
// front end, command queue and back end. Depends on smig_pkg, smig_front,
// smig_queue and smig_back.
//
//  Channel   Direction  Signals                         Content
//  s_*       in         tvalid tready tdata[39:0] tuser load / boundary / query
//  m_*       out        tvalid tready tdata[15:0] tuser tlast  one result entry
//  cfg_*     in         we index[1:0] data[10:0]        configuration write
//
//  A load is executed from the idle state of the back end. A query fetches
//  its boundaries through the states IDLE, BLO and BHI, then scans the vertices
//  and pads the empty slots for each list; the split is scanned twice when the
//  non-matching list is enabled. The single association memory read port
//  sets the scan rate: one vertex per cycle while no hit waits for a stalled
//  result register. Reset clears control state only; both memories start
//  undefined. A stalled result register holds the scan while the four-entry
//  queue keeps accepting input transactions until it is full.
`default_nettype none

module split_member_index_gather_top #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_SPLITS   = 64,
    parameter int MAX_MATCH    = 16,
    parameter int MAX_OTHER    = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // load_address[10:0], load_value[22:11], object_id[33:23], split_index[39:34]
    input  wire logic [39:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // vertex_index[10:0], slot[15:11]
    output logic [15:0]      m_tdata,
    // list_select[0]
    output logic             m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    logic [10:0] vertex_count_reg;
    logic [4:0]  match_limit_reg;
    logic [5:0]  other_limit_reg;
    logic        emit_others_reg;

    smig_pkg::cfg_t cfg;
    smig_pkg::cmd_t push_cmd;
    smig_pkg::cmd_t pop_cmd;
    logic           q_push, q_pop, q_full, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= 11'd1024;
            match_limit_reg  <= 5'd16;
            other_limit_reg  <= 6'd32;
            emit_others_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smig_pkg::CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data;
                smig_pkg::CFG_MATCH_LIMIT:  match_limit_reg  <= cfg_data[4:0];
                smig_pkg::CFG_OTHER_LIMIT:  other_limit_reg  <= cfg_data[5:0];
                smig_pkg::CFG_EMIT_OTHERS:  emit_others_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Saturate the settings to the build limits
    always_comb
    begin
        cfg.vc   = (32'(vertex_count_reg) > MAX_VERTICES) ?
                   11'(MAX_VERTICES) : vertex_count_reg;
        cfg.ml   = (32'(match_limit_reg) > MAX_MATCH) ?
                   6'(MAX_MATCH) : {1'b0, match_limit_reg};
        cfg.ol   = (32'(other_limit_reg) > MAX_OTHER) ?
                   6'(MAX_OTHER) : other_limit_reg;
        cfg.emit = emit_others_reg;
    end

    smig_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_SPLITS   (MAX_SPLITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    smig_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    smig_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_SPLITS   (MAX_SPLITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_match_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> ({1'b0, m_tdata[15:11]} < cfg.ml))
        else $error("matching list slot beyond its limit");

    a_other_list_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (cfg.emit && ({1'b0, m_tdata[15:11]} < cfg.ol)))
        else $error("non-matching entry while disabled or beyond its limit");

    a_vertex_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[10:0] != smig_pkg::PAD_INDEX)) |->
        (m_tdata[10:0] < cfg.vc))
        else $error("collected vertex index beyond vertex count");
`endif

endmodule

`default_nettype wire

FILE: dv/smig_gather_checker.sv
// Checker for the split member index gather block: watches the input, result and
// configuration channels, predicts each query's result list and compares it.
// Depends on smig_pkg for widths, action codes and register indexes.

module smig_gather_checker #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_SPLITS   = 64,
    parameter int MAX_MATCH    = 16,
    parameter int MAX_OTHER    = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // load_address[10:0], load_value[22:11], object_id[33:23], split_index[39:34]
    input  wire logic [39:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // vertex_index[10:0], slot[15:11]
    input  wire logic [15:0] m_tdata,
    // list_select[0]
    input  wire logic        m_tuser,
    input  wire logic        m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    output int               mismatches,
    output int               outstanding
);
    import smig_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   vertex_index;
        logic              list_select;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } gather_entry_t;

    logic [ID_W-1:0] assoc_ids [MAX_VERTICES];
    logic [ID_W-1:0] split_edges [MAX_SPLITS+1];
    logic [10:0]     vertex_count;
    logic [4:0]      match_limit;
    logic [5:0]      other_limit;
    logic            emit_others;
    gather_entry_t   expected_entries [$];

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches = mismatches + 1;
    endtask

    // Walk one list over the scan range, then pad it with the empty index.
    task automatic collect_list(input int unsigned first, input int unsigned stop,
                                input logic [ID_W-1:0] id, input bit want_match,
                                input int unsigned limit, input bit sel);
        gather_entry_t e;
        int unsigned   n;
        n = 0;
        e.list_select = sel;
        e.last = 1'b0;
        for (int unsigned v = first; v < stop && n < limit; v++)
        begin
            if ((assoc_ids[v] == id) == want_match)
            begin
                e.vertex_index = ID_W'(v);
                e.slot = SLOT_W'(n);
                expected_entries.push_back(e);
                n++;
            end
        end
        while (n < limit)
        begin
            e.vertex_index = PAD_INDEX;
            e.slot = SLOT_W'(n);
            expected_entries.push_back(e);
            n++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : model
        logic [1:0]       action;
        logic [10:0]      addr;
        logic [11:0]      value;
        logic [ID_W-1:0]  object_id;
        int unsigned      split, vc, ml, ol, lo, hi, prior;
        gather_entry_t    want;
        if (!rst_n)
        begin
            vertex_count = 11'd1024;
            match_limit = 5'd16;
            other_limit = 6'd32;
            emit_others = 1'b1;
            expected_entries.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_VERTEX_COUNT: vertex_count = cfg_data;
                    CFG_MATCH_LIMIT:  match_limit = cfg_data[4:0];
                    CFG_OTHER_LIMIT:  other_limit = cfg_data[5:0];
                    CFG_EMIT_OTHERS:  emit_others = cfg_data[0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_entries.size() == 0)
                    report_mismatch($sformatf("unexpected result index %0d list %0d slot %0d",
                                              $signed(m_tdata[10:0]), m_tuser, m_tdata[15:11]));
                else
                begin
                    want = expected_entries.pop_front();
                    if (m_tdata[10:0] !== want.vertex_index || m_tuser !== want.list_select ||
                        m_tdata[15:11] !== want.slot || m_tlast !== want.last)
                        report_mismatch($sformatf(
                            "index %0d list %0d slot %0d last %0d, expected %0d %0d %0d %0d",
                            $signed(m_tdata[10:0]), m_tuser, m_tdata[15:11], m_tlast,
                            $signed(want.vertex_index), want.list_select, want.slot, want.last));
                end
            end

            if (s_tvalid && s_tready)
            begin
                action = s_tuser;
                addr = s_tdata[10:0];
                value = s_tdata[22:11];
                object_id = s_tdata[33:23];
                split = s_tdata[39:34];
                case (action)
                    ACT_LOAD_ASSOC:
                        if (addr < MAX_VERTICES)
                            assoc_ids[addr] = value[ID_W-1:0];
                    ACT_LOAD_BOUND:
                        if (addr <= MAX_SPLITS)
                            split_edges[addr] = value[ID_W-1:0];
                    ACT_QUERY:
                    begin
                        vc = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
                        ml = (match_limit > MAX_MATCH) ? MAX_MATCH : match_limit;
                        ol = (other_limit > MAX_OTHER) ? MAX_OTHER : other_limit;
                        lo = 0;
                        hi = 0;
                        if (split < MAX_SPLITS)
                        begin
                            lo = split_edges[split];
                            hi = split_edges[split + 1];
                            if (hi > vc)
                                hi = vc;
                        end
                        prior = expected_entries.size();
                        collect_list(lo, hi, object_id, 1'b1, ml, 1'b0);
                        if (emit_others)
                            collect_list(lo, hi, object_id, 1'b0, ol, 1'b1);
                        // mark the final entry of the query
                        if (expected_entries.size() > prior)
                        begin
                            want = expected_entries.pop_back();
                            want.last = 1'b1;
                            expected_entries.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
            outstanding = expected_entries.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
// Top of the split member index gather testbench: clock, reset, stimulus,
// result sink, watchdog and verdict. Depends on smig_pkg, the block's top
// level and smig_gather_checker.

module tb_top;
    import smig_pkg::*;

    localparam int VERTICES       = 1024;
    localparam int SPLITS         = 64;
    localparam int WINDOW         = 100;
    localparam int DRAIN_CYCLES   = 12000;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES    = 600;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;
    int          mismatches;
    int          outstanding;
    int          watchdog = 0;

    // What the stimulus has already written, so that queries only read loaded entries
    bit          assoc_known [VERTICES];
    bit          bound_known [SPLITS+1];
    int unsigned bound_pos [SPLITS+1];
    int unsigned vc_eff = VERTICES;
    int unsigned sender_quiet = 0;

    split_member_index_gather_top dut (.*);

    smig_gather_checker checker_i (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            watchdog <= 0;
        else
        begin
            watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] act, input int unsigned addr, input int value,
                             input int id, input int unsigned split);
        int unsigned gap;
        if (sender_quiet > 0)
        begin
            gap = 0;
            sender_quiet--;
        end
        else
        begin
            gap = $urandom_range(0, 17);
            if ($urandom_range(0, 11) == 0)
                sender_quiet = $urandom_range(5, 30);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {split[5:0], id[10:0], value[11:0], addr[10:0]};
        do
            @(posedge clk);
        while (!s_tready);
        if (act == ACT_LOAD_ASSOC && addr < VERTICES)
            assoc_known[addr] = 1'b1;
        if (act == ACT_LOAD_BOUND && addr <= SPLITS)
        begin
            bound_known[addr] = 1'b1;
            bound_pos[addr] = value & 'h7FF;
        end
    endtask

    function automatic int pick_assoc_value();
        case ($urandom_range(0, 9))
            0: return -1;
            1: return 1024;
            2: return 1023;
            3: return $urandom_range(0, 1024);
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    // A split may be queried once its bounds and every clipped vertex are loaded.
    function automatic bit split_ready(input int unsigned sp);
        int unsigned lo, hi;
        if (!bound_known[sp] || !bound_known[sp+1])
            return 1'b0;
        lo = bound_pos[sp];
        hi = (bound_pos[sp+1] > vc_eff) ? vc_eff : bound_pos[sp+1];
        for (int unsigned v = lo; v < hi; v++)
        begin
            if (!assoc_known[v])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic send_random_item(output bit useful);
        int unsigned roll, sp, v;
        int          id, value;
        bit          found;
        useful = 1'b1;
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0: id = -1;
            1: id = 1023;
            2: id = $urandom_range(0, 1023);
            default: id = $urandom_range(0, 7);
        endcase
        if (roll < 5)
        begin
            useful = 1'b0;
            send_item(ACT_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 4095), id,
                      $urandom_range(0, 63));
        end
        else if (roll < 9)
        begin
            // out-of-range loads are dropped by the block
            useful = 1'b0;
            if (roll[0])
                send_item(ACT_LOAD_ASSOC, $urandom_range(VERTICES, 2047), pick_assoc_value(),
                          id, $urandom_range(0, 63));
            else
                send_item(ACT_LOAD_BOUND, $urandom_range(SPLITS + 1, 2047),
                          $urandom_range(0, WINDOW), id, $urandom_range(0, 63));
        end
        else if (roll < 27)
            send_item(ACT_LOAD_ASSOC, $urandom_range(0, WINDOW + 30), pick_assoc_value(), id,
                      $urandom_range(0, 63));
        else if (roll < 35)
        begin
            case ($urandom_range(0, 5))
                0: value = -1;
                1: value = 1024;
                2: value = $urandom_range(0, 4095);
                default: value = $urandom_range(0, WINDOW);
            endcase
            send_item(ACT_LOAD_BOUND, $urandom_range(0, SPLITS), value, id,
                      $urandom_range(0, 63));
        end
        else
        begin
            found = 1'b0;
            sp = 0;
            for (int t = 0; t < 8 && !found; t++)
            begin
                sp = $urandom_range(0, SPLITS - 1);
                found = split_ready(sp);
            end
            if (found)
                send_item(ACT_QUERY, $urandom_range(0, 2047), $urandom_range(0, 4095), id, sp);
            // otherwise steer the last split tried toward a small, fully loaded range
            else if (!bound_known[sp] || bound_pos[sp] > WINDOW)
                send_item(ACT_LOAD_BOUND, sp, $urandom_range(0, WINDOW), id,
                          $urandom_range(0, 63));
            else if (!bound_known[sp+1] || bound_pos[sp+1] > bound_pos[sp] + 40)
                send_item(ACT_LOAD_BOUND, sp + 1, bound_pos[sp] + $urandom_range(0, 24), id,
                          $urandom_range(0, 63));
            else
            begin
                v = bound_pos[sp];
                while (assoc_known[v])
                    v++;
                send_item(ACT_LOAD_ASSOC, v, pick_assoc_value(), id, $urandom_range(0, 63));
            end
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned done;
        bit          useful;
        done = 0;
        while (done < count)
        begin
            send_random_item(useful);
            if (useful)
                done++;
        end
    endtask

    // Drop valid, wait for every expected result, then let the back end finish.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic change_config(input int unsigned vc, input int unsigned ml,
                                 input int unsigned ol, input int unsigned emit);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_VERTEX_COUNT;
        cfg_data <= 11'(vc);
        @(posedge clk);
        cfg_index <= CFG_MATCH_LIMIT;
        cfg_data <= 11'(ml);
        @(posedge clk);
        cfg_index <= CFG_OTHER_LIMIT;
        cfg_data <= 11'(ol);
        @(posedge clk);
        cfg_index <= CFG_EMIT_OTHERS;
        cfg_data <= 11'(emit);
        @(posedge clk);
        cfg_we <= 1'b0;
        vc_eff = (vc > VERTICES) ? VERTICES : vc;
    endtask

    // Result sink: random stalls, quiet stretches and two long hold-offs.
    initial
    begin : result_sink
        int unsigned stall, taken, quiet;
        taken = 0;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == 40 || taken == 3000)
                stall = HOLD_CYCLES;
            else if (quiet > 0)
            begin
                stall = 0;
                quiet--;
            end
            else
            begin
                stall = $urandom_range(0, 17);
                if ($urandom_range(0, 9) == 0)
                    quiet = $urandom_range(5, 40);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            taken++;
        end
    end

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // wrapped and negative ids, ignored loads, empty and inverted splits
        send_item(ACT_LOAD_ASSOC, 0, 5, 0, 0);
        send_item(ACT_LOAD_ASSOC, 1, -1, -1, 63);
        send_item(ACT_LOAD_ASSOC, 2, 1024, 0, 0);
        send_item(ACT_LOAD_ASSOC, 3, 5, 0, 0);
        send_item(ACT_LOAD_ASSOC, 4, 1023, 0, 0);
        send_item(ACT_LOAD_ASSOC, 2047, 5, 0, 0);
        send_item(ACT_LOAD_BOUND, 0, 0, 0, 0);
        send_item(ACT_LOAD_BOUND, 1, 5, 0, 0);
        send_item(ACT_LOAD_BOUND, 2, 5, 0, 0);
        send_item(ACT_LOAD_BOUND, 3, 2, 0, 0);
        send_item(ACT_LOAD_BOUND, SPLITS + 1, 0, 0, 0);
        send_item(ACT_UNUSED, 0, 0, 5, 0);
        send_item(ACT_QUERY, 0, 0, 5, 0);
        send_item(ACT_QUERY, 0, 0, -1, 0);
        send_item(ACT_QUERY, 0, 0, 1023, 0);
        send_item(ACT_QUERY, 0, 0, 0, 0);
        send_item(ACT_QUERY, 2047, 4095, 5, 1);
        send_item(ACT_QUERY, 0, 0, 5, 2);
        run_random(40);

        // oversized registers saturate; the last split's end is clipped
        change_config(5, 31, 63, 1);
        send_item(ACT_LOAD_BOUND, SPLITS - 1, 0, 0, 0);
        send_item(ACT_LOAD_BOUND, SPLITS, -1, 0, 0);
        send_item(ACT_QUERY, 0, 0, 5, SPLITS - 1);
        run_random(30);

        change_config(0, 1, 1, 1);
        run_random(15);
        // no slots at all: queries give no results
        change_config(2047, 0, 0, 0);
        run_random(10);
        change_config(1024, 0, 7, 1);
        run_random(40);
        change_config(100, 3, 0, 1);
        run_random(40);
        change_config(64, 16, 32, 0);
        run_random(40);
        change_config(1024, 16, 32, 1);
        run_random(30);
        repeat (2)
        begin
            change_config($urandom_range(20, 130), $urandom_range(0, 31), $urandom_range(0, 63),
                          $urandom_range(0, 1));
            run_random(35);
        end

        drain();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
design/smig_pkg.sv
design/smig_front.sv
design/smig_queue.sv
design/smig_back.sv
design/split_member_index_gather_top.sv
dv/smig_gather_checker.sv
dv/tb_top.sv
